[hdl/grs_pkg.sv]
// Shared types and constants for the 2:1 grid restriction block.
`default_nettype none

package grs_pkg;

  // Parameter defaults
  localparam int DEF_MAX_COARSE_WIDTH  = 512;
  localparam int DEF_MAX_COARSE_HEIGHT = 512;
  localparam int DEF_SAMPLE_BITS       = 24;

  // Configuration port
  localparam int CFG_BITS     = 10;
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COARSE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COARSE_HEIGHT = 2'd1;
  localparam logic [CFG_BITS-1:0]     CFG_SIZE_RESET    = 10'd512;

  // Line store: one bank per fine row, three rows kept
  localparam int NUM_BANKS = 3;
  localparam int BANK_BITS = 2;

  // Per-item control decided at accept time, carried down the pipe
  typedef struct packed {
    logic                 emit;        // this item completes a coarse cell
    logic                 frame_last;  // last coarse cell of the grid
    logic                 row_last;    // last fine row: bottom edge clamp
    logic                 row_edge;    // top edge clamp on first tap
    logic                 col_last;    // last fine column: right edge clamp
    logic                 col_edge;    // left edge clamp on first tap
    logic [BANK_BITS-1:0] bank;        // bank holding row r-3 (row r mod 3)
  } grs_ctrl_t;

endpackage

`default_nettype wire

[hdl/grs_channels.sv]
// Handshake channel interfaces: fine sample input, coarse result output, config writes.
`default_nettype none

interface grs_in_if import grs_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] fine_sample;

  modport source (output valid, output fine_sample, input ready);
  modport sink   (input valid, input fine_sample, output ready);
endinterface

interface grs_out_if import grs_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] coarse_value;
  logic                          frame_last;

  modport source (output valid, output coarse_value, output frame_last, input ready);
  modport sink   (input valid, input coarse_value, input frame_last, output ready);
endinterface

interface grs_cfg_if import grs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CFG_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/grs_line_ram.sv]
// One bank of the fine row store: single address, read-before-write, registered read.
`default_nettype none

module grs_line_ram #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 24,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic                 we,
  input  wire logic [DATA_BITS-1:0] wdata,
  input  wire logic                 re,
  output logic      [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rdata_r;

  // Read returns the old contents when the same address is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/grs_window.sv]
// 4x4 sample window with vertical (1,3,3,1) column sums; pipeline stages B and C.
`default_nettype none

module grs_window import grs_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // accept stage
  input  wire logic                            acc,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample,
  input  wire grs_ctrl_t                       ctrl_in,
  output logic                                 in_ready,
  // registered line store reads, one per bank
  input  wire logic        [SAMPLE_BITS-1:0]   rd [NUM_BANKS],
  // toward the output stage
  input  wire logic                            o_take,
  output logic                                 c_emit,
  output grs_ctrl_t                            c_ctrl,
  output logic signed      [SAMPLE_BITS+2:0]   c_vsum [4]
);

  localparam int VW = SAMPLE_BITS + 3;

  // Stage B: sample and control of the item whose store reads are in flight
  logic                          vb_r;
  logic signed [SAMPLE_BITS-1:0] s_b_r;
  grs_ctrl_t                     ctrl_b_r;

  // Stage C: window and column sums
  logic                          vc_r;
  grs_ctrl_t                     ctrl_c_r;
  logic signed [SAMPLE_BITS-1:0] win_r [4][4];  // [column, 3 newest][row, 3 current]
  logic signed [VW-1:0]          vsum_r [4];

  logic                          free_c;
  logic                          move_b;
  logic                          free_b;
  logic signed [SAMPLE_BITS-1:0] new_col [4];
  logic signed [SAMPLE_BITS-1:0] win_nxt [4][4];
  logic signed [VW-1:0]          vsum_nxt [4];

  // Weighted (1,3,3,1) sum down one column with edge clamping
  function automatic logic signed [VW-1:0] col_sum(
    input logic signed [SAMPLE_BITS-1:0] c0,
    input logic signed [SAMPLE_BITS-1:0] c1,
    input logic signed [SAMPLE_BITS-1:0] c2,
    input logic signed [SAMPLE_BITS-1:0] c3,
    input logic                          last,
    input logic                          edg
  );
    logic signed [VW-1:0] t0;
    logic signed [VW-1:0] t1;
    logic signed [VW-1:0] t2;
    logic signed [VW-1:0] t3;
    logic signed [VW-1:0] mid;
    if (last) begin
      t0 = edg ? VW'(c2) : VW'(c1);
      t1 = VW'(c2);
      t2 = VW'(c3);
    end else begin
      t0 = edg ? VW'(c1) : VW'(c0);
      t1 = VW'(c1);
      t2 = VW'(c2);
    end
    t3  = VW'(c3);
    mid = t1 + t2;
    return t0 + mid + (mid <<< 1) + t3;
  endfunction

  // Handshake: stages collapse bubbles, C drains when it has no result
  assign free_c   = !vc_r || !ctrl_c_r.emit || o_take;
  assign move_b   = vb_r && free_c;
  assign free_b   = !vb_r || move_b;
  assign in_ready = free_b;

  // New column: rows r-3, r-2, r-1 from the rotating banks, then row r
  always_comb begin
    unique case (ctrl_b_r.bank)
      2'd1: begin
        new_col[0] = rd[1];
        new_col[1] = rd[2];
        new_col[2] = rd[0];
      end
      2'd2: begin
        new_col[0] = rd[2];
        new_col[1] = rd[0];
        new_col[2] = rd[1];
      end
      default: begin
        new_col[0] = rd[0];
        new_col[1] = rd[1];
        new_col[2] = rd[2];
      end
    endcase
    new_col[3] = s_b_r;
  end

  // Shift the window by one column and sum each column
  always_comb begin
    for (int x = 0; x < 3; x++) begin
      win_nxt[x] = win_r[x + 1];
    end
    win_nxt[3] = new_col;
    for (int x = 0; x < 4; x++) begin
      vsum_nxt[x] = col_sum(win_nxt[x][0], win_nxt[x][1], win_nxt[x][2], win_nxt[x][3],
                            ctrl_b_r.row_last, ctrl_b_r.row_edge);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (free_b) begin
        vb_r <= acc;
      end
      if (free_c) begin
        vc_r <= move_b;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (acc) begin
      s_b_r    <= sample;
      ctrl_b_r <= ctrl_in;
    end
    if (move_b) begin
      win_r    <= win_nxt;
      vsum_r   <= vsum_nxt;
      ctrl_c_r <= ctrl_b_r;
    end
  end

  assign c_emit = vc_r && ctrl_c_r.emit;
  assign c_ctrl = ctrl_c_r;
  assign c_vsum = vsum_r;

endmodule

`default_nettype wire

[hdl/grs_out.sv]
// Horizontal (1,3,3,1) sum, divide by 64 rounding half up, result register.
`default_nettype none

module grs_out import grs_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          c_emit,
  input  wire grs_ctrl_t                     c_ctrl,
  input  wire logic signed [SAMPLE_BITS+2:0] c_vsum [4],
  output logic                               o_take,
  grs_out_if.source                          out_ch
);

  localparam int HW = SAMPLE_BITS + 6;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] value_r;
  logic                          last_r;

  logic signed [HW-1:0] t0;
  logic signed [HW-1:0] t1;
  logic signed [HW-1:0] t2;
  logic signed [HW-1:0] t3;
  logic signed [HW-1:0] mid;
  logic signed [HW-1:0] hsum;
  logic signed [HW-1:0] rounded;
  logic signed [SAMPLE_BITS-1:0] value_nxt;

  assign o_take = !out_valid_r || out_ch.ready;

  // Column taps with left/right edge clamping
  always_comb begin
    if (c_ctrl.col_last) begin
      t0 = c_ctrl.col_edge ? HW'(c_vsum[2]) : HW'(c_vsum[1]);
      t1 = HW'(c_vsum[2]);
      t2 = HW'(c_vsum[3]);
    end else begin
      t0 = c_ctrl.col_edge ? HW'(c_vsum[1]) : HW'(c_vsum[0]);
      t1 = HW'(c_vsum[1]);
      t2 = HW'(c_vsum[2]);
    end
    t3        = HW'(c_vsum[3]);
    mid       = t1 + t2;
    hsum      = t0 + mid + (mid <<< 1) + t3;
    rounded   = (hsum + HW'(32)) >>> 6;
    value_nxt = rounded[SAMPLE_BITS-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_take) begin
      out_valid_r <= c_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (o_take && c_emit) begin
      value_r <= value_nxt;
      last_r  <= c_ctrl.frame_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.coarse_value = value_r;
  assign out_ch.frame_last   = last_r;

endmodule

`default_nettype wire

[hdl/grid_restrict_2to1_top.sv]
// Top level of the 2:1 cell-centered grid restriction: config, raster counters, line store.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+----------------------------------------
//   in_ch    | in  | valid/ready       | fine_sample (SAMPLE_BITS, signed)
//   out_ch   | out | valid/ready       | coarse_value (SAMPLE_BITS, signed), frame_last
//   cfg_ch   | in  | valid/ready (=1)  | index (0 width, 1 height), data (10 bits)
//
// One fine item per cycle, sustained while in_ch.ready stays high. The item that completes
// a result passes store read/stage B, window and column sums (stage C), row sum and round.
// Synchronous reset clears control only; the line store needs no clearing pass.
// Empty stages absorb output stalls; in_ch.ready drops only when stage B is full, stage C
// holds a result, the result register is full and out_ch.ready is low.
// A config write to the width or height register restarts the frame.
`default_nettype none

module grid_restrict_2to1_top import grs_pkg::*; #(
  parameter int MAX_COARSE_WIDTH  = DEF_MAX_COARSE_WIDTH,
  parameter int MAX_COARSE_HEIGHT = DEF_MAX_COARSE_HEIGHT,
  parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  grs_in_if.sink    in_ch,
  grs_out_if.source out_ch,
  grs_cfg_if.sink   cfg_ch
);

  localparam int FINE_MAX_W = 2 * MAX_COARSE_WIDTH;
  localparam int CWB        = $clog2(MAX_COARSE_WIDTH + 1);
  localparam int CHB        = $clog2(MAX_COARSE_HEIGHT + 1);
  localparam int FCW        = $clog2(FINE_MAX_W);
  localparam int FRB        = $clog2(2 * MAX_COARSE_HEIGHT);

  logic [CFG_BITS-1:0]  cw_cfg_r;
  logic [CFG_BITS-1:0]  ch_cfg_r;
  logic [FCW-1:0]       col_r;
  logic [FRB-1:0]       row_r;
  logic [BANK_BITS-1:0] bank_r;

  logic                 acc;
  logic                 in_ready;
  logic                 cfg_wr;
  logic                 restart;
  logic [CWB-1:0]       cw_eff;
  logic [CHB-1:0]       ch_eff;
  logic [FCW-1:0]       col_last;
  logic [FRB-1:0]       row_last;
  logic                 at_col_last;
  logic                 at_row_last;
  logic                 col_ok;
  logic                 row_ok;
  grs_ctrl_t            ctrl;

  logic                 o_take;
  logic                 c_emit;
  grs_ctrl_t            c_ctrl;
  logic signed [SAMPLE_BITS+2:0] c_vsum [4];
  logic [SAMPLE_BITS-1:0]        rd [NUM_BANKS];

  assign acc          = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign restart      = cfg_wr && ((cfg_ch.index == REG_COARSE_WIDTH) ||
                                   (cfg_ch.index == REG_COARSE_HEIGHT));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_cfg_r <= CFG_SIZE_RESET;
      ch_cfg_r <= CFG_SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        REG_COARSE_WIDTH:  cw_cfg_r <= cfg_ch.data;
        REG_COARSE_HEIGHT: ch_cfg_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, oversize saturates
  always_comb begin
    if (cw_cfg_r == '0) begin
      cw_eff = CWB'(1);
    end else if (32'(cw_cfg_r) > MAX_COARSE_WIDTH) begin
      cw_eff = CWB'(MAX_COARSE_WIDTH);
    end else begin
      cw_eff = CWB'(cw_cfg_r);
    end
    if (ch_cfg_r == '0) begin
      ch_eff = CHB'(1);
    end else if (32'(ch_cfg_r) > MAX_COARSE_HEIGHT) begin
      ch_eff = CHB'(MAX_COARSE_HEIGHT);
    end else begin
      ch_eff = CHB'(ch_cfg_r);
    end
  end

  assign col_last = FCW'({cw_eff - CWB'(1), 1'b1});
  assign row_last = FRB'({ch_eff - CHB'(1), 1'b1});

  // Emission and edge clamping for the current fine position
  always_comb begin
    at_col_last = (col_r == col_last);
    at_row_last = (row_r == row_last);
    col_ok      = at_col_last || (!col_r[0] && (32'(col_r) >= 32'd2));
    row_ok      = at_row_last || (!row_r[0] && (32'(row_r) >= 32'd2));

    ctrl.emit       = col_ok && row_ok;
    ctrl.frame_last = at_col_last && at_row_last;
    ctrl.col_last   = at_col_last;
    ctrl.row_last   = at_row_last;
    ctrl.col_edge   = at_col_last ? (cw_eff == CWB'(1)) : (32'(col_r) == 32'd2);
    ctrl.row_edge   = at_row_last ? (ch_eff == CHB'(1)) : (32'(row_r) == 32'd2);
    ctrl.bank       = bank_r;
  end

  // Raster position and the bank that takes the current row
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r  <= '0;
      row_r  <= '0;
      bank_r <= '0;
    end else if (acc) begin
      if (at_col_last) begin
        col_r <= '0;
        if (at_row_last) begin
          row_r  <= '0;
          bank_r <= '0;
        end else begin
          row_r  <= row_r + FRB'(1);
          bank_r <= (bank_r == BANK_BITS'(NUM_BANKS - 1)) ? '0 : bank_r + BANK_BITS'(1);
        end
      end else begin
        col_r <= col_r + FCW'(1);
      end
    end
  end

  // Line store: three fine rows, all read at the current column
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    grs_line_ram #(
      .DEPTH     (FINE_MAX_W),
      .DATA_BITS (SAMPLE_BITS),
      .ADDR_BITS (FCW)
    ) u_ram (
      .clk   (clk),
      .addr  (col_r),
      .we    (acc && (bank_r == BANK_BITS'(b))),
      .wdata (in_ch.fine_sample),
      .re    (acc),
      .rdata (rd[b])
    );
  end

  grs_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .sample   (in_ch.fine_sample),
    .ctrl_in  (ctrl),
    .in_ready (in_ready),
    .rd       (rd),
    .o_take   (o_take),
    .c_emit   (c_emit),
    .c_ctrl   (c_ctrl),
    .c_vsum   (c_vsum)
  );

  grs_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .c_emit (c_emit),
    .c_ctrl (c_ctrl),
    .c_vsum (c_vsum),
    .o_take (o_take),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

[tb/sv/grid_restrict_2to1_top_test.sv]
// Self-checking testbench for the 2:1 grid restriction block: directed table, then random frames.
`default_nettype none

module grid_restrict_2to1_top_test;
  import grs_pkg::*;

  localparam int SB          = DEF_SAMPLE_BITS;
  localparam int MAXW        = DEF_MAX_COARSE_WIDTH;
  localparam int MAXH        = DEF_MAX_COARSE_HEIGHT;
  localparam int LINE_W      = 2 * MAXW;
  localparam int RAND_ITEMS  = 800;
  localparam int QUIET_TAIL  = 200;
  localparam int DRAIN_WAIT  = 8;
  localparam int END_WAIT    = 12;
  localparam int LONG_HOLD   = 80;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DIR_ROWS    = 33;

  typedef logic signed [SB-1:0] sample_t;

  localparam sample_t S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SB-1){1'b0}}};

  typedef struct packed {
    sample_t value;
    logic    last;
  } coarse_t;

  typedef enum logic [0:0] { ROW_ITEM, ROW_CFG } row_kind_t;

  // One row of the directed table: a register write or one item
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [CFG_BITS-1:0]     reg_val;
    sample_t                 sample;
    logic                    fixed;    // expectation typed in below
    logic                    f_emit;
    sample_t                 f_value;
    logic                    f_last;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  grs_in_if  #(.SAMPLE_BITS(SB)) in_if ();
  grs_out_if #(.SAMPLE_BITS(SB)) out_if ();
  grs_cfg_if                     cfg_if ();

  grid_restrict_2to1_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // Directed stimulus
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    // after reset the grid is 512x512: nothing completes
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MIN, 1'b1, 1'b0, '0, 1'b0},
    // 1x1 coarse grid: the cell is the mean of four equal samples
    '{ROW_CFG,  REG_COARSE_WIDTH,  10'd1, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_CFG,  REG_COARSE_HEIGHT, 10'd1, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MAX, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MAX, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MAX, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MAX, 1'b1, 1'b1, S_MAX, 1'b1},
    // frame wraps, second frame at the negative extreme
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MIN, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MIN, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MIN, 1'b1, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MIN, 1'b1, 1'b1, S_MIN, 1'b1},
    // zero sizes act as one; half-way rounding goes up
    '{ROW_CFG,  REG_COARSE_WIDTH,  10'd0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_CFG,  REG_COARSE_HEIGHT, 10'd0, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(2), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(0), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(0), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(0), 1'b0, 1'b0, '0, 1'b0},
    // partial frame, then a write restarts it with an oversize height
    '{ROW_CFG,  REG_COARSE_WIDTH,  10'd2, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(100), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(-100), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(5), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_CFG,  REG_COARSE_HEIGHT, 10'd1023, '0, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MAX, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, S_MIN, 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(1), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(-1), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(24'h555555), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(24'hAAAAAA), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(7), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(-7), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(0), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(3), 1'b0, 1'b0, '0, 1'b0},
    '{ROW_ITEM, REG_COARSE_WIDTH,  '0, sample_t'(-3), 1'b0, 1'b0, '0, 1'b0}
  };

  // Restriction predictor state
  logic [CFG_BITS-1:0] size_w = CFG_SIZE_RESET;
  logic [CFG_BITS-1:0] size_h = CFG_SIZE_RESET;
  sample_t             line_mem [0:3*LINE_W-1];
  sample_t             win [4][4];    // [column, 3 newest][row, 3 current]
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;

  coarse_t cells_due [$];
  int      fail_count  = 0;
  int      cycle_count = 0;
  int      fed         = 0;
  bit      no_idle     = 1'b0;
  int      hold_req    = 0;
  int      hold_ack    = 0;
  int      hold_left   = 0;
  int      stall_left  = 0;

  initial begin
    foreach (line_mem[k]) line_mem[k] = '0;
    foreach (win[a, b]) win[a][b] = '0;
  end

  function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int tap(input int k);
    return (k == 0 || k == 3) ? 1 : 3;
  endfunction

  // Advance the predictor by one fine sample; report the finished coarse cell if any
  function automatic void restrict_step(input sample_t s, output bit emit, output coarse_t res);
    int unsigned cw, ch, fw, fh, c, r, ci, cj, rp, cp;
    int unsigned rix [4];
    int unsigned cix [4];
    bit          row_ok, col_ok;
    longint      acc;
    cw = eff_size(size_w, MAXW);
    ch = eff_size(size_h, MAXH);
    fw = 2 * cw;
    fh = 2 * ch;
    c = col_pos;
    r = row_pos;
    if (c >= fw) c = 0;
    if (r >= fh) r = 0;
    emit = 1'b0;
    res  = '0;

    // shift in the new column: three stored rows plus the new sample
    for (int k = 0; k < 3; k++) win[k] = win[k+1];
    win[3][0] = line_mem[((r + 0) % 3) * LINE_W + c];
    win[3][1] = line_mem[((r + 1) % 3) * LINE_W + c];
    win[3][2] = line_mem[((r + 2) % 3) * LINE_W + c];
    win[3][3] = s;
    line_mem[(r % 3) * LINE_W + c] = s;

    cj = 0;
    ci = 0;
    row_ok = 1'b0;
    col_ok = 1'b0;
    if (r == fh - 1) begin
      cj = ch - 1; row_ok = 1'b1;
    end else if (r[0] == 1'b0 && r >= 2) begin
      cj = r / 2 - 1; row_ok = 1'b1;
    end
    if (c == fw - 1) begin
      ci = cw - 1; col_ok = 1'b1;
    end else if (c[0] == 1'b0 && c >= 2) begin
      ci = c / 2 - 1; col_ok = 1'b1;
    end

    if (row_ok && col_ok) begin
      // clamp taps at the edges, weights stay as they are
      rix[0] = (cj > 0) ? 2 * cj - 1 : 2 * cj;
      rix[1] = 2 * cj;
      rix[2] = 2 * cj + 1;
      rix[3] = (cj + 1 < ch) ? 2 * cj + 2 : 2 * cj + 1;
      cix[0] = (ci > 0) ? 2 * ci - 1 : 2 * ci;
      cix[1] = 2 * ci;
      cix[2] = 2 * ci + 1;
      cix[3] = (ci + 1 < cw) ? 2 * ci + 2 : 2 * ci + 1;
      acc = 0;
      for (int y = 0; y < 4; y++) begin
        rp = (3 - ((r - rix[y]) & 3)) & 3;
        for (int x = 0; x < 4; x++) begin
          cp = (3 - ((c - cix[x]) & 3)) & 3;
          acc += longint'(tap(x) * tap(y)) * longint'(win[cp][rp]);
        end
      end
      // divide by 64, round half up
      res.value = sample_t'((acc + 32) >>> 6);
      res.last  = (r == fh - 1 && c == fw - 1);
      emit = 1'b1;
    end

    c++;
    if (c >= fw) begin
      c = 0;
      r++;
      if (r >= fh) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  task automatic log_fail(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk) begin
    coarse_t want;
    if (rst_n === 1'b1 && out_if.valid && out_if.ready) begin
      if (cells_due.size() == 0) begin
        log_fail($sformatf("unexpected result: coarse_value %0d frame_last %0b",
                           out_if.coarse_value, out_if.frame_last));
      end else begin
        want = cells_due.pop_front();
        if (out_if.coarse_value !== want.value || out_if.frame_last !== want.last)
          log_fail($sformatf("mismatch: coarse_value exp %0d got %0d, frame_last exp %0b got %0b",
                             want.value, out_if.coarse_value, want.last, out_if.frame_last));
      end
    end
  end

  // Result receiver: random stall bursts and requested long holds
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n !== 1'b1) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD - 1;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Drop valid and wait until every expected cell is out and the pipe is empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_COARSE_WIDTH) size_w = val;
    else size_h = val;
    // any write restarts the frame
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic send_item(input sample_t s, input bit fixed, input bit f_emit,
                           input coarse_t f_res);
    bit      emit;
    coarse_t res;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.fine_sample <= s;
    do @(posedge clk); while (!in_if.ready);
    restrict_step(s, emit, res);
    if (fixed) begin
      emit = f_emit;
      res  = f_res;
    end
    if (emit) cells_due.push_back(res);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return sample_t'(int'($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_BITS'($urandom_range(7, 12));
      default: return CFG_BITS'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic int frame_items();
    return 4 * eff_size(size_w, MAXW) * eff_size(size_h, MAXH);
  endfunction

  // Random content, with an occasional pause until the block drains
  task automatic feed(input int n);
    for (int k = 0; k < n; k++) begin
      if (!no_idle && $urandom_range(0, 63) == 0) settle();
      send_item(rand_sample(), 1'b0, 1'b0, '0);
      fed++;
    end
  endtask

  task automatic set_size(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
    write_reg(REG_COARSE_WIDTH, w);
    write_reg(REG_COARSE_HEIGHT, h);
  endtask

  // Main sequence
  initial begin
    int rand_base, fsz, n;
    logic [CFG_BITS-1:0] w, h;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.fine_sample <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG)
        write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_val);
      else
        send_item(dir_tab[k].sample, dir_tab[k].fixed, dir_tab[k].f_emit,
                  {dir_tab[k].f_value, dir_tab[k].f_last});
    end

    // widest grid, saturated width and zero height: part of the first row
    set_size(10'd1023, 10'd0);
    feed(120);
    // tallest grids, partial frames
    set_size(10'd0, 10'd1023);
    feed(80);
    set_size(10'd1, 10'd512);
    feed(60);
    set_size(10'd512, 10'd512);
    feed(40);

    // receiver holds off while the sender keeps going, then the sender waits for drain
    set_size(10'd4, 10'd4);
    hold_req++;
    feed(30);
    settle();
    feed(98);

    // random small grids: mostly whole frames, some cut short by a restart
    rand_base = fed;
    while (fed - rand_base < RAND_ITEMS) begin
      if (fed - rand_base >= RAND_ITEMS - QUIET_TAIL) no_idle = 1'b1;
      w = pick_size();
      h = pick_size();
      case ($urandom_range(0, 3))
        0:       write_reg(REG_COARSE_WIDTH, w);
        1:       write_reg(REG_COARSE_HEIGHT, h);
        default: set_size(w, h);
      endcase
      fsz = frame_items();
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, fsz);
      else if (fsz > 200) n = fsz;
      else n = fsz * $urandom_range(1, 2);
      feed(n);
    end

    // wind down
    in_if.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
